FILE: rtl/psns_pkg.sv
// Shared constants, codes and types of the point store with nearest search.
package psns_pkg;

  localparam int CAPACITY   = 256;
  localparam int COORD_BITS = 16;

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int DIST_W = SQ_W + 1;
  localparam int PT_W   = 2 * COORD_BITS;

  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 8;
  localparam int RCNT_W   = 9;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_FIND   = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // One candidate point leaving the distance pipeline.
  typedef struct packed {
    logic [IDX_W-1:0]             idx;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [DIST_W-1:0]            sq_dist;
  } cand_t;

  // One result, as it is held before and in the output register.
  typedef struct packed {
    logic [STATUS_W-1:0]          status;
    logic [SLOT_W-1:0]            slot_index;
    logic signed [COORD_BITS-1:0] near_x;
    logic signed [COORD_BITS-1:0] near_y;
    logic [RCNT_W-1:0]            removed_count;
    logic [RCNT_W-1:0]            entries_now;
  } rsp_t;

endpackage

FILE: rtl/psns_req_if.sv
// Request channel: operation kind and position, with valid and ready.
interface psns_req_if import psns_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [KIND_W-1:0]            kind;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;

  modport source (output valid, kind, pos_x, pos_y, input ready);
  modport sink   (input valid, kind, pos_x, pos_y, output ready);
endinterface

FILE: rtl/psns_rsp_if.sv
// Response channel: status, index, nearest point and counts, with valid and ready.
interface psns_rsp_if import psns_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [STATUS_W-1:0]          status;
  logic [SLOT_W-1:0]            slot_index;
  logic signed [COORD_BITS-1:0] near_x;
  logic signed [COORD_BITS-1:0] near_y;
  logic [RCNT_W-1:0]            removed_count;
  logic [RCNT_W-1:0]            entries_now;

  modport source (output valid, status, slot_index, near_x, near_y, removed_count,
                  entries_now, input ready);
  modport sink   (input valid, status, slot_index, near_x, near_y, removed_count,
                  entries_now, output ready);
endinterface

FILE: rtl/point_store_nearest_search.sv
// Top level of the point store: table control, scan sequencing and result register.
//
// Usage: requests arrive on req_i (kind, pos_x, pos_y) and each one produces exactly
// one response on rsp_o; both channels move a request when valid and ready are high
// at a rising edge. Points sit in one synchronous RAM, one {x, y} word per entry.
// An insert writes the entry behind the last one. A delete reads every entry once,
// one per cycle, and writes each survivor back to the next compacted place in the
// same pass. A find streams every entry through a two-stage squared-distance
// pipeline and keeps the strictly smaller distance, so the lowest index wins ties.
// The block works on one request at a time: ready is high only while no request is
// in work. A finished response waits in the output register, and a new request is
// taken meanwhile; if the receiver still stalls when that next one is done, the block
// holds it and waits.
// Reset (rst_ni low, asynchronous) empties the table and drops any pending response;
// the RAM contents are not cleared, since only entries below the count are ever read.
module point_store_nearest_search import psns_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  psns_req_if.sink   req_i,
  psns_rsp_if.source rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Request being worked on.
  kind_e                        kind_q, kind_d;
  logic signed [COORD_BITS-1:0] px_q, py_q;

  // Table and scan bookkeeping.
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]  keep_q, keep_d;
  logic [RCNT_W-1:0] removed_q, removed_d;

  // Read data from the RAM is valid in the cycle after the read.
  logic             p1_vld_q;
  logic [IDX_W-1:0] p1_idx_q;

  // Best candidate of a find so far.
  logic  best_vld_q, best_vld_d;
  cand_t best_q, best_d;

  rsp_t res_q, res_d;
  rsp_t out_q, out_d;
  logic out_vld_q, out_vld_d;

  // RAM ports.
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [PT_W-1:0]  ram_wdata, ram_rdata;

  logic signed [COORD_BITS-1:0] rd_x, rd_y;
  logic                         rd_match;

  logic  dist_vld, dist_busy;
  cand_t dist_cand;

  logic req_fire, rsp_fire, scan_left, scan_end;

  assign rd_x     = ram_rdata[PT_W-1:COORD_BITS];
  assign rd_y     = ram_rdata[COORD_BITS-1:0];
  assign rd_match = (rd_x == px_q) && (rd_y == py_q);

  assign req_fire  = req_i.valid && req_i.ready;
  assign rsp_fire  = out_vld_q && rsp_o.ready;
  assign scan_left = rd_idx_q < count_q;
  assign scan_end  = (state_q == S_SCAN) && !scan_left && !p1_vld_q && !dist_busy;

  psns_ram #(
    .WIDTH(PT_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  psns_dist u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(p1_vld_q && (kind_q == KIND_FIND)),
    .idx_i  (p1_idx_q),
    .x_i    (rd_x),
    .y_i    (rd_y),
    .px_i   (px_q),
    .py_i   (py_q),
    .valid_o(dist_vld),
    .cand_o (dist_cand),
    .busy_o (dist_busy)
  );

  // The scan reads ahead of the compaction write: the write index never passes the
  // read index, so a survivor never overwrites an entry that is still to be read.
  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    count_d    = count_q;
    rd_idx_d   = rd_idx_q;
    keep_d     = keep_q;
    removed_d  = removed_q;
    best_vld_d = best_vld_q;
    best_d     = best_q;
    res_d      = res_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    ram_we     = 1'b0;
    ram_waddr  = count_q[IDX_W-1:0];
    ram_wdata  = {req_i.pos_x, req_i.pos_y};
    ram_re     = 1'b0;
    ram_raddr  = rd_idx_q[IDX_W-1:0];

    if (rsp_fire) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          kind_d     = kind_e'(req_i.kind);
          rd_idx_d   = '0;
          keep_d     = '0;
          removed_d  = '0;
          best_vld_d = 1'b0;
          res_d      = '0;
          res_d.entries_now = RCNT_W'(count_q);
          state_d    = S_DONE;
          case (req_i.kind)
            KIND_INSERT: begin
              if (count_q >= CNT_W'(CAPACITY)) begin
                res_d.status = STATUS_FULL;
              end else begin
                ram_we            = 1'b1;
                count_d           = count_q + 1'b1;
                res_d.slot_index  = SLOT_W'(count_q);
                res_d.entries_now = RCNT_W'(count_q + 1'b1);
              end
            end
            KIND_DELETE: begin
              state_d = S_SCAN;
            end
            KIND_FIND: begin
              if (count_q == '0) begin
                res_d.status = STATUS_EMPTY;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: begin
              // Unused kind: no change, an all-zero response with the count.
            end
          endcase
        end
      end

      S_SCAN: begin
        if (scan_left) begin
          ram_re   = 1'b1;
          rd_idx_d = rd_idx_q + 1'b1;
        end
        if (p1_vld_q && (kind_q == KIND_DELETE)) begin
          if (rd_match) begin
            removed_d = removed_q + 1'b1;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = keep_q[IDX_W-1:0];
            ram_wdata = ram_rdata;
            keep_d    = keep_q + 1'b1;
          end
        end
        if (dist_vld && (!best_vld_q || (dist_cand.sq_dist < best_q.sq_dist))) begin
          best_vld_d = 1'b1;
          best_d     = dist_cand;
        end
        if (scan_end) begin
          state_d = S_DONE;
          res_d   = '0;
          if (kind_q == KIND_DELETE) begin
            count_d             = keep_q;
            res_d.removed_count = removed_q;
            res_d.entries_now   = RCNT_W'(keep_q);
          end else begin
            res_d.slot_index  = SLOT_W'(best_q.idx);
            res_d.near_x      = best_q.x;
            res_d.near_y      = best_q.y;
            res_d.entries_now = RCNT_W'(count_q);
          end
        end
      end

      S_DONE: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      rd_idx_q   <= '0;
      keep_q     <= '0;
      removed_q  <= '0;
      p1_vld_q   <= 1'b0;
      best_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      rd_idx_q   <= rd_idx_d;
      keep_q     <= keep_d;
      removed_q  <= removed_d;
      p1_vld_q   <= ram_re;
      best_vld_q <= best_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      px_q <= req_i.pos_x;
      py_q <= req_i.pos_y;
    end
    kind_q   <= kind_d;
    p1_idx_q <= rd_idx_q[IDX_W-1:0];
    best_q   <= best_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  assign req_i.ready = (state_q == S_IDLE);

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.status        = out_q.status;
  assign rsp_o.slot_index    = out_q.slot_index;
  assign rsp_o.near_x        = out_q.near_x;
  assign rsp_o.near_y        = out_q.near_y;
  assign rsp_o.removed_count = out_q.removed_count;
  assign rsp_o.entries_now   = out_q.entries_now;

endmodule

FILE: rtl/psns_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module psns_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/psns_dist.sv
// Two-stage squared-distance pipeline: squares of the differences, then their sum.
module psns_dist import psns_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [IDX_W-1:0]             idx_i,
  input  logic signed [COORD_BITS-1:0] x_i,
  input  logic signed [COORD_BITS-1:0] y_i,
  input  logic signed [COORD_BITS-1:0] px_i,
  input  logic signed [COORD_BITS-1:0] py_i,
  output logic                         valid_o,
  output cand_t                        cand_o,
  output logic                         busy_o
);

  logic signed [DIFF_W-1:0]   dx, dy;
  logic signed [2*DIFF_W-1:0] sqx_full, sqy_full;

  logic                         a_vld_q;
  logic [IDX_W-1:0]             a_idx_q;
  logic signed [COORD_BITS-1:0] a_x_q, a_y_q;
  logic [SQ_W-1:0]              a_sqx_q, a_sqy_q;

  logic  b_vld_q;
  cand_t b_cand_q;

  always_comb begin
    dx       = DIFF_W'(x_i) - DIFF_W'(px_i);
    dy       = DIFF_W'(y_i) - DIFF_W'(py_i);
    sqx_full = dx * dx;
    sqy_full = dy * dy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      a_vld_q <= valid_i;
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_idx_q          <= idx_i;
    a_x_q            <= x_i;
    a_y_q            <= y_i;
    a_sqx_q          <= sqx_full[SQ_W-1:0];
    a_sqy_q          <= sqy_full[SQ_W-1:0];
    b_cand_q.idx     <= a_idx_q;
    b_cand_q.x       <= a_x_q;
    b_cand_q.y       <= a_y_q;
    b_cand_q.sq_dist <= {1'b0, a_sqx_q} + {1'b0, a_sqy_q};
  end

  assign valid_o = b_vld_q;
  assign cand_o  = b_cand_q;
  assign busy_o  = a_vld_q | b_vld_q;

endmodule

FILE: verif/point_store_nearest_search_test.sv
// Self-checking testbench of the point store with nearest-point search.
module point_store_nearest_search_test import psns_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // The kind code that the block must treat as a no-op.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // Run limits. The slowest legal request is a full-table scan. Together with sender
  // gaps and receiver stalls, a whole run stays far below the cycle limit.
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int          DRAIN_CYCLES = 300;
  localparam int          MAX_REPORTS  = 10;
  localparam int          RANDOM_ITEMS = 110;

  logic clk_i;
  logic rst_ni;

  psns_req_if req_if ();
  psns_rsp_if rsp_if ();

  point_store_nearest_search i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Shadow copy of the point table, kept in step with every accepted request.
  coord_t      shadow_x [CAPACITY];
  coord_t      shadow_y [CAPACITY];
  int unsigned shadow_count;

  // Responses that the block still owes, oldest first.
  rsp_t predicted_answers[$];

  int unsigned mismatch_count;
  int unsigned cycle_count;

  // Percentages of idle sender cycles and stalled receiver cycles.
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Every block input is known from time zero.
  initial begin
    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.kind        = '0;
    req_if.pos_x       = '0;
    req_if.pos_y       = '0;
    rsp_if.ready       = 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    mismatch_count     = 0;
    shadow_count       = 0;
  end

  // The cycle counter guards against a hung block.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    cycle_count = 0;
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // The receiver drops ready at random, as the current phase asks.
  always @(posedge clk_i) begin
    rsp_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // Applies one operation to the shadow table and returns the response it must give.
  // Find keeps the first strictly smaller squared distance, so the lowest index wins
  // ties. Squared distances stay below 2^33 and are held in 64 bits.
  function automatic rsp_t apply_table_op(logic [KIND_W-1:0] kind, coord_t px, coord_t py);
    rsp_t        answer;
    int unsigned keep;
    int unsigned removed;
    int unsigned best;
    longint      dx;
    longint      dy;
    longint      sq_dist;
    longint      best_dist;

    answer    = '0;
    removed   = 0;
    best      = 0;
    best_dist = 0;
    case (kind)
      KIND_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          answer.status = STATUS_FULL;
        end else begin
          shadow_x[shadow_count] = px;
          shadow_y[shadow_count] = py;
          answer.slot_index      = SLOT_W'(shadow_count);
          shadow_count++;
        end
      end
      KIND_DELETE: begin
        // Survivors move down in their original order.
        keep = 0;
        for (int unsigned i = 0; i < shadow_count; i++) begin
          if (shadow_x[i] == px && shadow_y[i] == py) begin
            removed++;
          end else begin
            shadow_x[keep] = shadow_x[i];
            shadow_y[keep] = shadow_y[i];
            keep++;
          end
        end
        shadow_count         = keep;
        answer.removed_count = RCNT_W'(removed);
      end
      KIND_FIND: begin
        if (shadow_count == 0) begin
          answer.status = STATUS_EMPTY;
        end else begin
          for (int unsigned i = 0; i < shadow_count; i++) begin
            dx      = longint'(px) - longint'(shadow_x[i]);
            dy      = longint'(py) - longint'(shadow_y[i]);
            sq_dist = dx * dx + dy * dy;
            if (i == 0 || sq_dist < best_dist) begin
              best      = i;
              best_dist = sq_dist;
            end
          end
          answer.slot_index = SLOT_W'(best);
          answer.near_x     = shadow_x[best];
          answer.near_y     = shadow_y[best];
        end
      end
      default: begin
      end
    endcase
    answer.entries_now = RCNT_W'(shadow_count);
    return answer;
  endfunction

  // Sends one request after a random sender gap. Valid is lowered only when a gap
  // follows, so back-to-back requests never see two assignments in one time step.
  // The caller is aligned to a rising edge on entry and on return.
  task automatic send_request(logic [KIND_W-1:0] kind, coord_t px, coord_t py);
    int unsigned gap;
    rsp_t        answer;

    gap = 0;
    while ($urandom_range(0, 99) < sender_idle_pct && gap < 40) begin
      gap++;
    end
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.kind  <= kind;
    req_if.pos_x <= px;
    req_if.pos_y <= py;
    @(posedge clk_i);
    while (!req_if.ready) begin
      @(posedge clk_i);
    end
    // Accepted at this edge: the table changes now, in request order.
    answer            = apply_table_op(kind, px, py);
    predicted_answers = {predicted_answers, answer};
  endtask

  // Each accepted response is checked against the oldest prediction.
  always @(posedge clk_i) begin
    rsp_t expected;
    logic bad;

    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (predicted_answers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected response: status %0d slot %0d near (%0d,%0d) removed %0d count %0d",
                   rsp_if.status, rsp_if.slot_index, rsp_if.near_x, rsp_if.near_y,
                   rsp_if.removed_count, rsp_if.entries_now);
        end
      end else begin
        expected = predicted_answers.pop_front();
        bad = (rsp_if.status !== expected.status)
           || (rsp_if.slot_index !== expected.slot_index)
           || (rsp_if.near_x !== expected.near_x)
           || (rsp_if.near_y !== expected.near_y)
           || (rsp_if.removed_count !== expected.removed_count)
           || (rsp_if.entries_now !== expected.entries_now);
        if (bad) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("response mismatch at cycle %0d", cycle_count);
            $display("  expected: status %0d slot %0d near (%0d,%0d) removed %0d count %0d",
                     expected.status, expected.slot_index, expected.near_x,
                     expected.near_y, expected.removed_count, expected.entries_now);
            $display("  actual:   status %0d slot %0d near (%0d,%0d) removed %0d count %0d",
                     rsp_if.status, rsp_if.slot_index, rsp_if.near_x, rsp_if.near_y,
                     rsp_if.removed_count, rsp_if.entries_now);
          end
        end
      end
    end
  end

  // Coordinates lean toward a small grid around zero, which makes duplicates for
  // delete and equal distances for find, with extremes and full-range values mixed in.
  function automatic coord_t pick_coord();
    coord_t c;

    case ($urandom_range(0, 9)) inside
      [0:3]: c = coord_t'($urandom_range(0, 8) - 4);
      4: begin
        case ($urandom_range(0, 3))
          0: c = coord_t'(16'sh8000);
          1: c = coord_t'(16'sh7fff);
          2: c = coord_t'(0);
          default: c = coord_t'(-1);
        endcase
      end
      default: c = coord_t'($urandom());
    endcase
    return c;
  endfunction

  // A delete mostly targets a stored point so that it actually removes something.
  task automatic send_delete_of_stored();
    int unsigned pick;

    if (shadow_count > 0 && $urandom_range(0, 9) < 8) begin
      pick = $urandom_range(0, shadow_count - 1);
      send_request(KIND_DELETE, shadow_x[pick], shadow_y[pick]);
    end else begin
      send_request(KIND_DELETE, pick_coord(), pick_coord());
    end
  endtask

  task automatic set_idling(int unsigned idle_pct, int unsigned stall_pct);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
  endtask

  // Empty-table cases, coordinate extremes, ties, compaction and the unused kind.
  task automatic test_directed();
    send_request(KIND_FIND, 0, 0);
    send_request(KIND_DELETE, 0, 0);
    send_request(KIND_UNUSED, 0, 0);
    send_request(KIND_INSERT, -16'sd32768, -16'sd32768);
    // The largest squared distance the fields allow.
    send_request(KIND_FIND, 16'sd32767, 16'sd32767);
    send_request(KIND_INSERT, 16'sd32767, 16'sd32767);
    send_request(KIND_INSERT, 0, 0);
    send_request(KIND_INSERT, 0, 0);
    send_request(KIND_INSERT, 1, -1);
    send_request(KIND_INSERT, -1, 1);
    // Two equal points: the first one must win.
    send_request(KIND_FIND, 0, 0);
    // Equal distance to two different points: the lower index must win.
    send_request(KIND_FIND, 0, -1);
    send_request(KIND_FIND, -1, 16'sd32767);
    send_request(KIND_DELETE, 5, 5);
    send_request(KIND_UNUSED, 16'sd32767, -16'sd32768);
    // Removing both copies shifts the later points down.
    send_request(KIND_DELETE, 0, 0);
    send_request(KIND_FIND, 0, 0);
    send_request(KIND_DELETE, -16'sd32768, -16'sd32768);
    send_request(KIND_FIND, -16'sd32768, -16'sd32768);
    send_request(KIND_INSERT, -16'sd32768, 16'sd32767);
    send_request(KIND_INSERT, 16'sd32767, -16'sd32768);
    send_request(KIND_FIND, -16'sd32768, 16'sd32767);
    send_request(KIND_FIND, 16'sd32767, -16'sd32768);
  endtask

  // Fills the table to capacity, then checks inserts on a full table, a full-length
  // scan, and a heavy compaction that removes the repeated points again.
  task automatic test_full_table();
    coord_t pool_x [6];
    coord_t pool_y [6];
    int unsigned k;

    foreach (pool_x[i]) begin
      pool_x[i] = pick_coord();
      pool_y[i] = pick_coord();
    end
    while (shadow_count < CAPACITY) begin
      if ($urandom_range(0, 1) == 0) begin
        k = $urandom_range(0, 5);
        send_request(KIND_INSERT, pool_x[k], pool_y[k]);
      end else begin
        send_request(KIND_INSERT, pick_coord(), pick_coord());
      end
    end
    repeat (3) send_request(KIND_INSERT, pick_coord(), pick_coord());
    send_request(KIND_FIND, pick_coord(), pick_coord());
    send_request(KIND_FIND, shadow_x[CAPACITY-1], shadow_y[CAPACITY-1]);
    send_request(KIND_UNUSED, pick_coord(), pick_coord());
    send_request(KIND_DELETE, shadow_x[0], shadow_y[0]);
    send_request(KIND_INSERT, 16'sd32767, -16'sd32768);
    foreach (pool_x[i]) begin
      send_request(KIND_DELETE, pool_x[i], pool_y[i]);
      send_request(KIND_FIND, pick_coord(), pick_coord());
    end
  endtask

  // Random mix of operations. The table size drifts up and down, with inserts
  // made rarer once it grows past 160 entries so that scans of every length occur.
  task automatic test_random_mix(int unsigned count);
    int unsigned roll;
    int unsigned insert_pct;

    repeat (count) begin
      insert_pct = (shadow_count > 160) ? 25 : 50;
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        send_request(KIND_UNUSED, pick_coord(), pick_coord());
      end else if (roll < 2 + insert_pct) begin
        send_request(KIND_INSERT, pick_coord(), pick_coord());
      end else if (roll < 2 + insert_pct + 18) begin
        send_delete_of_stored();
      end else begin
        send_request(KIND_FIND, pick_coord(), pick_coord());
      end
    end
  endtask

  // Reset once, run the tests in turn under changing idling, drain and report.
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(0, 0);
    test_directed();
    set_idling(21, 21);
    test_full_table();
    set_idling(0, 0);
    test_random_mix(RANDOM_ITEMS);
    set_idling(69, 0);
    test_random_mix(RANDOM_ITEMS);
    set_idling(0, 69);
    test_random_mix(RANDOM_ITEMS);
    set_idling(21, 21);
    test_random_mix(RANDOM_ITEMS);

    req_if.valid <= 1'b0;
    while (predicted_answers.size() != 0) begin
      @(posedge clk_i);
    end
    // Any late extra response would show up within one full scan.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && predicted_answers.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
